// File: rtl/core/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GOB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gob check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GOB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gob check failed");

`endif

// File: rtl/core/gob_pkg.sv
package gob_pkg;

    localparam int ANGLE_BITS = 6;
    localparam int MAG_LIMIT  = 255;

    localparam int ANG_AW     = 2 * ANGLE_BITS;
    localparam int ANG_DEPTH  = 1 << ANG_AW;
    localparam int CM_W       = $clog2(MAG_LIMIT + 1);
    localparam int PROB_AW    = CM_W + 8;
    localparam int PROB_DEPTH = (MAG_LIMIT + 1) * 256;

    localparam logic [1:0] CMD_PIXEL    = 2'd0;
    localparam logic [1:0] CMD_ANGLE_WR = 2'd1;
    localparam logic [1:0] CMD_PROB_WR  = 2'd2;
    localparam logic [1:0] CMD_FRAME    = 2'd3;

    localparam logic [7:0] REG_STEP   = 8'd0;
    localparam logic [7:0] REG_PERIOD = 8'd1;

    localparam logic [7:0]  STEP_RESET   = 8'd1;
    localparam logic [15:0] PERIOD_RESET = 16'd16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int LEVEL_W     = 3;

    // first member lands in the upper bits
    typedef struct packed {
        logic [7:0] new_bg_angle;
        logic [7:0] fg_probability;
    } result_t;

    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
    } queue_status_t;

endpackage

// File: rtl/core/gradient_orientation_background.sv
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    tuser: cmd; tdata: pixels, bg angle, table write, start
// m_       out  m_tvalid/m_tready    tdata: fg_probability, new_bg_angle
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (0 step_size, 1 update_period)
//
// One word per clock in while s_tready is high; a pixel's result reaches m_tvalid through
// the angle table read, the probability table read and the queue write.
// Table writes and frame starts give no result.
// Reset clears the pixel counter, pipeline valids and queue, and loads the config reset values; tables are undefined.
// A 4-word result queue absorbs m_tready stalls; s_tready falls once in-flight plus
// queued words reach 4.
module gradient_orientation_background (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [79:64] start_count, [63:56] table_data, [55:40] table_addr, [39:32] bg_angle,
    // [31:24] lower_pixel, [23:16] upper_pixel, [15:8] right_pixel, [7:0] left_pixel
    input  logic [79:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:8] new_bg_angle, [7:0] fg_probability
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import gob_pkg::*;

    logic [7:0]  angle_mem [ANG_DEPTH];
    logic [7:0]  prob_mem  [PROB_DEPTH];

    logic [7:0]  left_px, right_px, upper_px, lower_px, bg_in, wr_data;
    logic [15:0] wr_addr, start_cnt;
    logic        s_acc, pix_acc;

    logic signed [8:0]  dx, dy;
    logic signed [17:0] dx_sq, dy_sq;
    logic [8:0]  dx_off, dy_off;
    logic [ANG_AW-1:0] aidx;

    logic [7:0]  step_reg, step_next;
    logic [15:0] period_reg, period_next;
    logic [15:0] pix_cnt_reg, pix_cnt_next, cnt_inc;
    logic        upd_now;

    logic        s1_valid_reg;
    logic [15:0] s1_sqx_reg, s1_sqy_reg;
    logic [7:0]  s1_bg_reg;
    logic        s1_upd_reg;
    logic [7:0]  ang_rd_reg;

    logic [7:0]  diff;
    logic [16:0] mag;
    logic [CM_W-1:0]    cm;
    logic [PROB_AW-1:0] pidx;
    logic [7:0]  nb;

    logic        s2_valid_reg;
    logic [7:0]  s2_nb_reg;
    logic [7:0]  prob_rd_reg;

    result_t       push_word, head_word;
    queue_status_t q_status;
    logic [LEVEL_W-1:0] inflight;

    assign left_px   = s_tdata[7:0];
    assign right_px  = s_tdata[15:8];
    assign upper_px  = s_tdata[23:16];
    assign lower_px  = s_tdata[31:24];
    assign bg_in     = s_tdata[39:32];
    assign wr_addr   = s_tdata[55:40];
    assign wr_data   = s_tdata[63:56];
    assign start_cnt = s_tdata[79:64];

    assign inflight = LEVEL_W'(s1_valid_reg) + LEVEL_W'(s2_valid_reg) + q_status.level;
    assign s_tready = (inflight < LEVEL_W'(QUEUE_DEPTH));
    assign s_acc    = s_tvalid && s_tready;
    assign pix_acc  = s_acc && (s_tuser == CMD_PIXEL);
    assign cfg_ready = 1'b1;

    // front: differences, squares, angle table address
    always_comb
    begin
        dx     = $signed({1'b0, left_px}) - $signed({1'b0, right_px});
        dy     = $signed({1'b0, upper_px}) - $signed({1'b0, lower_px});
        dx_sq  = dx * dx;
        dy_sq  = dy * dy;
        dx_off = {1'b0, left_px} - {1'b0, right_px} + 9'h100;
        dy_off = {1'b0, upper_px} - {1'b0, lower_px} + 9'h100;
        aidx   = {dy_off[8 -: ANGLE_BITS], dx_off[8 -: ANGLE_BITS]};
    end

    // counter and configuration
    always_comb
    begin
        cnt_inc      = pix_cnt_reg + 16'd1;
        upd_now      = (cnt_inc == period_reg);
        pix_cnt_next = pix_cnt_reg;
        if (pix_acc)
        begin
            pix_cnt_next = upd_now ? 16'd0 : cnt_inc;
        end
        else if (s_acc && (s_tuser == CMD_FRAME))
        begin
            pix_cnt_next = (start_cnt < period_reg) ? start_cnt : 16'd0;
        end

        step_next   = step_reg;
        period_next = period_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STEP:   step_next   = cfg_data[7:0];
                REG_PERIOD: period_next = cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_RESET;
            period_reg   <= PERIOD_RESET;
            pix_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            period_reg   <= period_next;
            pix_cnt_reg  <= pix_cnt_next;
            s1_valid_reg <= pix_acc;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sqx_reg <= dx_sq[15:0];
        s1_sqy_reg <= dy_sq[15:0];
        s1_bg_reg  <= bg_in;
        s1_upd_reg <= upd_now;
        s2_nb_reg  <= nb;
    end

    // angle table: write on table command, read on every cycle for the front item
    always_ff @(posedge clk)
    begin
        if (s_acc && (s_tuser == CMD_ANGLE_WR) && ({1'b0, wr_addr} < 17'(ANG_DEPTH)))
        begin
            angle_mem[wr_addr[ANG_AW-1:0]] <= wr_data;
        end
        ang_rd_reg <= angle_mem[aidx];
    end

    // middle: wrapped difference, clamped magnitude, angle nudge
    always_comb
    begin
        diff = ang_rd_reg - s1_bg_reg;
        mag  = {1'b0, s1_sqx_reg} + {1'b0, s1_sqy_reg};
        cm   = (mag < 17'(MAG_LIMIT)) ? mag[CM_W-1:0] : CM_W'(MAG_LIMIT);
        pidx = {cm, diff};
        nb   = s1_bg_reg;
        if (s1_upd_reg && diff[7])
        begin
            nb = s1_bg_reg - step_reg;
        end
        else if (s1_upd_reg && (diff != 8'd0))
        begin
            nb = s1_bg_reg + step_reg;
        end
    end

    // probability table: read-before-write keeps the older pixel ahead of a newer write
    always_ff @(posedge clk)
    begin
        if (s_acc && (s_tuser == CMD_PROB_WR) && ({1'b0, wr_addr} < 17'(PROB_DEPTH)))
        begin
            prob_mem[wr_addr[PROB_AW-1:0]] <= wr_data;
        end
        prob_rd_reg <= prob_mem[pidx];
    end

    assign push_word.new_bg_angle   = s2_nb_reg;
    assign push_word.fg_probability = prob_rd_reg;

    gob_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (push_word),
        .pop       (m_tvalid && m_tready),
        .out_data  (head_word),
        .status    (q_status)
    );

    assign m_tvalid = q_status.valid;
    assign m_tdata  = head_word;

endmodule

// File: rtl/core/gob_queue.sv
module gob_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  gob_pkg::result_t       push_data,
    input  logic                   pop,
    output gob_pkg::result_t       out_data,
    output gob_pkg::queue_status_t status
);
    import gob_pkg::*;

    result_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [LEVEL_W-1:0]    level_reg;
    logic [LEVEL_W-1:0]    level_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        level_next  = level_reg + LEVEL_W'(push) - LEVEL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_data     = slot_reg[rd_ptr_reg];
    assign status.valid = (level_reg != '0);
    assign status.level = level_reg;

endmodule

// File: rtl/core/gob_checker.sv
`include "assert_macros.svh"

module gob_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    import gob_pkg::*;

    logic pix_acc;
    assign pix_acc = rst_n && s_tvalid && s_tready && (s_tuser == CMD_PIXEL);

    // a held result word keeps its value
    `GOB_ASSERT_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))

    // an empty output only fills from an accepted pixel word
    `GOB_ASSERT_IMP(a_latency, $rose(m_tvalid), $past(pix_acc, 3))

    // input back-pressure only comes from results piling up
    `GOB_ASSERT_IMP(a_stall_cause, !s_tready, m_tvalid)

    // register writes never wait
    `GOB_ASSERT_IMP(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind gradient_orientation_background gob_checker u_gob_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import gob_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  left_px;
        logic [7:0]  right_px;
        logic [7:0]  upper_px;
        logic [7:0]  lower_px;
        logic [7:0]  bg_angle;
        logic [15:0] table_addr;
        logic [7:0]  table_data;
        logic [15:0] start_count;
    } stream_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_PIXEL;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = REG_STEP;
    logic [15:0] cfg_data = '0;

    gradient_orientation_background dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state, updated as words are accepted
    logic [7:0]  mdl_ang [ANG_DEPTH];
    logic [7:0]  mdl_prob [PROB_DEPTH];
    logic [15:0] pix_count = '0;
    logic [7:0]  step_sz = STEP_RESET;
    logic [15:0] period = PERIOD_RESET;

    // table contents as seen when words are queued, so pixels only hit written entries
    logic [7:0]  gen_ang [ANG_DEPTH];
    bit          gen_ang_ok [ANG_DEPTH];
    logic [7:0]  gen_prob [PROB_DEPTH];
    bit          gen_prob_ok [PROB_DEPTH];

    stream_word_t stim_words[$];
    stream_word_t cur_word;
    stream_word_t next_word;
    result_t      fg_expected[$];

    int  errors = 0;
    int  cycles = 0;
    int  n_checked = 0;
    int  n_tab_wr = 0;
    int  n_frames = 0;
    int  n_settings = 0;
    int  src_idle = 0;
    int  sink_stall = 0;
    bit  bursty = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_err(input string msg);
        $display("ERROR @%0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic int gap_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(4, 30));
    endfunction

    function automatic int angle_index(input logic [7:0] l, r, u, d);
        int dx;
        int dy;
        int xi;
        int yi;
        dx = int'(l) - int'(r);
        dy = int'(u) - int'(d);
        // dx + 256 is a 9-bit value; keep its top ANGLE_BITS
        xi = (dx + 256) >>> (9 - ANGLE_BITS);
        yi = (dy + 256) >>> (9 - ANGLE_BITS);
        return ((yi << ANGLE_BITS) + xi) & (ANG_DEPTH - 1);
    endfunction

    function automatic int prob_index(input logic [7:0] l, r, u, d, input logic [7:0] diff);
        int dx;
        int dy;
        int mag;
        dx = int'(l) - int'(r);
        dy = int'(u) - int'(d);
        mag = dx * dx + dy * dy;
        if (mag > MAG_LIMIT)
            mag = MAG_LIMIT;
        return mag * 256 + int'(diff);
    endfunction

    task automatic bg_subtract_step(input stream_word_t w);
        logic [ANG_AW-1:0] aidx;
        logic [7:0]        diff;
        logic [7:0]        nb;
        result_t           res;
        case (w.cmd)
            CMD_ANGLE_WR:
            begin
                if (w.table_addr < ANG_DEPTH)
                    mdl_ang[w.table_addr[ANG_AW-1:0]] = w.table_data;
                n_tab_wr++;
            end
            CMD_PROB_WR:
            begin
                if (w.table_addr < PROB_DEPTH)
                    mdl_prob[w.table_addr[PROB_AW-1:0]] = w.table_data;
                n_tab_wr++;
            end
            CMD_FRAME:
            begin
                pix_count = (w.start_count < period) ? w.start_count : 16'd0;
                n_frames++;
            end
            default:
            begin
                aidx = ANG_AW'(angle_index(w.left_px, w.right_px, w.upper_px, w.lower_px));
                diff = mdl_ang[aidx] - w.bg_angle;
                res.fg_probability = mdl_prob[PROB_AW'(prob_index(w.left_px, w.right_px,
                                                                  w.upper_px, w.lower_px,
                                                                  diff))];
                nb = w.bg_angle;
                pix_count = pix_count + 16'd1;
                if (pix_count == period)
                begin
                    pix_count = '0;
                    if (diff >= 8'h80)
                        nb = w.bg_angle - step_sz;
                    else if (diff != 8'd0)
                        nb = w.bg_angle + step_sz;
                end
                res.new_bg_angle = nb;
                fg_expected.push_back(res);
            end
        endcase
    endtask

    // source side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_idle <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                bg_subtract_step(cur_word);
            if (!s_tvalid || s_tready)
            begin
                if (src_idle != 0)
                begin
                    src_idle <= src_idle - 1;
                    s_tvalid <= 1'b0;
                end
                else if (stim_words.size() != 0)
                begin
                    next_word = stim_words.pop_front();
                    cur_word <= next_word;
                    s_tuser  <= next_word.cmd;
                    s_tdata  <= {next_word.start_count, next_word.table_data,
                                 next_word.table_addr, next_word.bg_angle,
                                 next_word.lower_px, next_word.upper_px,
                                 next_word.right_px, next_word.left_px};
                    s_tvalid <= 1'b1;
                    src_idle <= bursty ? 0 : gap_len();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (fg_expected.size() == 0)
                    report_err($sformatf("result word %h with nothing expected", m_tdata));
                else
                begin
                    result_t want;
                    result_t got;
                    want = fg_expected.pop_front();
                    got  = result_t'(m_tdata);
                    if (got.fg_probability !== want.fg_probability)
                        report_err($sformatf("fg_probability got %0d want %0d",
                                             got.fg_probability, want.fg_probability));
                    if (got.new_bg_angle !== want.new_bg_angle)
                        report_err($sformatf("new_bg_angle got %0d want %0d",
                                             got.new_bg_angle, want.new_bg_angle));
                    n_checked++;
                end
            end
            if (sink_stall != 0)
            begin
                sink_stall <= sink_stall - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!bursty && $urandom_range(0, 3) == 0)
                    sink_stall <= gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic stream_word_t rand_word(input logic [1:0] cmd);
        stream_word_t w;
        w.cmd         = cmd;
        w.left_px     = 8'($urandom);
        w.right_px    = 8'($urandom);
        w.upper_px    = 8'($urandom);
        w.lower_px    = 8'($urandom);
        w.bg_angle    = 8'($urandom);
        w.table_addr  = 16'($urandom);
        w.table_data  = 8'($urandom);
        w.start_count = 16'($urandom);
        return w;
    endfunction

    task automatic queue_angle_wr(input int addr, input int data);
        stream_word_t w;
        w = rand_word(CMD_ANGLE_WR);
        w.table_addr = 16'(addr);
        w.table_data = 8'(data);
        if (addr < ANG_DEPTH)
        begin
            gen_ang[ANG_AW'(addr)]    = w.table_data;
            gen_ang_ok[ANG_AW'(addr)] = 1'b1;
        end
        stim_words.push_back(w);
    endtask

    task automatic queue_prob_wr(input int addr, input int data);
        stream_word_t w;
        w = rand_word(CMD_PROB_WR);
        w.table_addr = 16'(addr);
        w.table_data = 8'(data);
        if (addr < PROB_DEPTH)
        begin
            gen_prob[PROB_AW'(addr)]    = w.table_data;
            gen_prob_ok[PROB_AW'(addr)] = 1'b1;
        end
        stim_words.push_back(w);
    endtask

    task automatic queue_frame(input int start);
        stream_word_t w;
        w = rand_word(CMD_FRAME);
        w.start_count = 16'(start);
        stim_words.push_back(w);
    endtask

    // with by_diff set, bg is the wanted angle difference rather than the angle
    task automatic queue_pixel(input int l, r, u, d, input int bg, input bit by_diff);
        stream_word_t       w;
        logic [ANG_AW-1:0]  aidx;
        logic [PROB_AW-1:0] pidx;
        logic [7:0]         diff;
        w = rand_word(CMD_PIXEL);
        w.left_px  = 8'(l);
        w.right_px = 8'(r);
        w.upper_px = 8'(u);
        w.lower_px = 8'(d);
        aidx = ANG_AW'(angle_index(w.left_px, w.right_px, w.upper_px, w.lower_px));
        if (!gen_ang_ok[aidx])
            queue_angle_wr(int'(aidx), int'($urandom_range(0, 255)));
        w.bg_angle = by_diff ? gen_ang[aidx] - 8'(bg) : 8'(bg);
        diff = gen_ang[aidx] - w.bg_angle;
        pidx = PROB_AW'(prob_index(w.left_px, w.right_px, w.upper_px, w.lower_px, diff));
        if (!gen_prob_ok[pidx])
            queue_prob_wr(int'(pidx), int'($urandom_range(0, 255)));
        stim_words.push_back(w);
    endtask

    function automatic int near_val(input int base);
        int v;
        v = base + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v;
    endfunction

    task automatic random_chunk(input int n_pix);
        int made;
        int sel;
        int base;
        int diffs[5];
        made   = 0;
        diffs  = '{0, 1, 127, 128, 255};
        bursty = ($urandom_range(0, 3) == 0);
        while (made < n_pix)
        begin
            sel = int'($urandom_range(0, 99));
            if (sel < 8)
                queue_frame($urandom_range(0, 1) ? $urandom_range(0, int'(period) - 1)
                                                 : $urandom_range(0, 65535));
            else if (sel < 14)
                queue_angle_wr($urandom_range(0, 1) ? $urandom_range(0, ANG_DEPTH - 1)
                                                    : $urandom_range(0, 65535),
                               $urandom_range(0, 255));
            else if (sel < 20)
                queue_prob_wr($urandom_range(0, 65535), $urandom_range(0, 255));
            else
            begin
                // half the pixels sit in flat areas so the magnitude can fall under the clamp
                base = int'($urandom_range(0, 255));
                if ($urandom_range(0, 1))
                begin
                    if ($urandom_range(0, 2) == 0)
                        queue_pixel(near_val(base), near_val(base), near_val(base),
                                    near_val(base), diffs[3'($urandom_range(0, 4))], 1'b1);
                    else
                        queue_pixel(near_val(base), near_val(base), near_val(base),
                                    near_val(base), $urandom_range(0, 255), 1'b0);
                end
                else
                    queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255), 1'($urandom_range(0, 1)));
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (stim_words.size() != 0 || s_tvalid || fg_expected.size() != 0);
        // writes and frame starts may still be in the pipe
        repeat (8) @(negedge clk);
        bursty = 1'b0;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_STEP)
            step_sz = val[7:0];
        else if (idx == REG_PERIOD)
            period = val;
        @(negedge clk);
    endtask

    initial
    begin
        int step_set[4];
        int period_set[4];
        int st;
        int pd;
        step_set   = '{255, 0, -1, 128};
        period_set = '{1, 65535, -1, 3};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part under reset settings
        queue_angle_wr(0, 8'h5a);
        queue_angle_wr(ANG_DEPTH, 8'ha5);
        queue_angle_wr(16'hffff, 8'h33);
        queue_prob_wr(16'hffff, 8'hff);
        queue_prob_wr(0, 8'h00);
        queue_pixel(0, 255, 0, 255, 0, 1'b0);
        queue_pixel(255, 0, 255, 0, 255, 1'b0);
        queue_pixel(0, 0, 0, 0, 0, 1'b1);
        queue_pixel(255, 255, 255, 255, 128, 1'b1);
        queue_pixel(10, 9, 7, 7, 3, 1'b1);
        queue_pixel(20, 5, 3, 0, 200, 1'b1);
        queue_frame(15);
        queue_pixel(40, 30, 60, 61, 5, 1'b1);
        queue_frame(15);
        queue_pixel(100, 120, 90, 80, 128, 1'b1);
        queue_frame(15);
        queue_pixel(7, 7, 8, 8, 0, 1'b1);
        queue_frame(15);
        queue_pixel(200, 190, 3, 9, 127, 1'b1);
        queue_frame(16);
        queue_frame(16'hffff);
        queue_pixel(1, 2, 3, 4, 255, 1'b1);
        wait_idle();
        random_chunk(16);
        wait_idle();
        random_chunk(16);
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            st = (step_set[p] < 0) ? int'($urandom_range(0, 255)) : step_set[p];
            pd = (period_set[p] < 0) ? int'($urandom_range(2, 40)) : period_set[p];
            write_reg(REG_STEP, 16'(st));
            write_reg(REG_PERIOD, 16'(pd));
            n_settings++;
            // land exactly on an update, then a start count that is too large
            queue_frame(pd - 1);
            queue_pixel(50, 52, 49, 47, 200, 1'b1);
            queue_frame(pd);
            random_chunk(16);
            wait_idle();
            random_chunk(16);
            wait_idle();
        end

        $display("checked %0d pixel results; %0d table writes and %0d frame starts applied",
                 n_checked, n_tab_wr, n_frames);
        $display("register settings tried beyond reset: %0d", n_settings);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
